FILE: rtl/scu_pkg.sv
package scu_pkg;

  localparam int DATA_W          = 32;
  localparam int OPC_W           = 4;
  localparam int NAME_ID_W       = 16;
  localparam int ACT_W           = 2;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VAR_ENTRIES = 32;
  localparam int DEF_NAME_BITS   = 16;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_WRITE  = 4'd4,
    OP_READ   = 4'd5,
    OP_JUMP   = 4'd6,
    OP_JUMPZ  = 4'd7,
    OP_ASSIGN = 4'd8,
    OP_QUERY  = 4'd9
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CONTINUE = 2'd0,
    ACT_JUMP     = 2'd1,
    ACT_END      = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_RD_A,
    S_ALU,
    S_WB,
    S_POP,
    S_SEARCH,
    S_VAL_RD,
    S_FINISH
  } state_t;

  // Search engine status, valid in the cycle done is high.
  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

FILE: rtl/scu_ram.sv
module scu_ram import scu_pkg::*; #(
  parameter int W     = DATA_W,
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/scu_alu.sv
module scu_alu import scu_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  alu_op_t           op,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] y
);

  logic [DATA_W-1:0] res;

  // 32-bit wrapping arithmetic; product keeps the low word.
  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      ALU_MUL: res = a * b;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= res;
    end
  end

endmodule

FILE: rtl/scu_search.sv
module scu_search import scu_pkg::*; #(
  parameter int NW  = DEF_NAME_BITS,
  parameter int VIW = 5,
  parameter int VCW = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  key,
  input  logic [VCW-1:0] count,
  output logic [VIW-1:0] rd_addr,
  input  logic [NW-1:0]  rd_data,
  output srch_stat_t     stat,
  output logic [VIW-1:0] hit_idx
);

  logic           busy_r, busy_nxt;
  logic [VCW-1:0] k_r, k_nxt;
  logic [VCW-1:0] cnt_r;
  logic [NW-1:0]  key_r;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic [VIW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic           hit_now;
  logic           more;

  // One compare per cycle against the entry read in the previous cycle.
  assign hit_now = cmp_vld_r && (rd_data == key_r);
  assign more    = (k_r < cnt_r);
  assign rd_addr = k_r[VIW-1:0];
  assign hit_idx = cmp_idx_r;

  always_comb begin
    busy_nxt    = busy_r;
    k_nxt       = k_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    stat.done   = 1'b0;
    stat.hit    = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (hit_now || !more) begin
        busy_nxt  = 1'b0;
        stat.done = 1'b1;
        stat.hit  = hit_now;
      end else begin
        k_nxt       = k_r + VCW'(1);
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = k_r[VIW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    if (start) begin
      key_r <= key;
      cnt_r <= count;
    end
  end

endmodule

FILE: rtl/stack_calculator_execute_unit.sv
// Channel  | Handshake          | Beat contents
// ---------+--------------------+-----------------------------------------------------
// in_      | in_valid/in_ready  | opcode, operand_value, name_id, target_exists
// out_     | out_valid/out_ready| next_action, read_value, stack_overflow, table_full
//
// One instruction at a time; in_ready is high only while the sequencer idles.
// PUSH/JUMP end at decode, JUMPZ may pop; ADD/SUB/MUL read up to two words, compute, write back.
// Variable ops walk the name table, one compare per cycle.
// Reset (rst_n low, synchronous) empties stack and table; no clearing pass is needed.
// A result waiting on out_ready holds the next instruction in its final step.
module stack_calculator_execute_unit import scu_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VAR_ENTRIES = DEF_VAR_ENTRIES,
  parameter int NAME_BITS   = DEF_NAME_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic signed [DATA_W-1:0] in_operand_value,
  input  logic [NAME_ID_W-1:0]     in_name_id,
  input  logic                     in_target_exists,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ACT_W-1:0]         out_next_action,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_stack_overflow,
  output logic                     out_table_full
);

  // Only the low NAME_BITS bits of a name are significant.
  localparam int NW  = (NAME_BITS < NAME_ID_W) ? NAME_BITS : NAME_ID_W;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int VIW = (VAR_ENTRIES > 1) ? $clog2(VAR_ENTRIES) : 1;
  localparam int VCW = $clog2(VAR_ENTRIES + 1);

  state_t            state_r, state_nxt;

  // latched instruction
  op_t               op_r;
  logic [DATA_W-1:0] val_r;
  logic [NW-1:0]     name_r;
  logic              exists_r;

  logic [SCW-1:0]    cnt_r, cnt_nxt;
  logic [VCW-1:0]    vcnt_r, vcnt_nxt;
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, opv_r, opv_nxt;

  // result under construction
  act_t              act_r, act_nxt;
  logic [DATA_W-1:0] rdv_r, rdv_nxt;
  logic              ovf_r, ovf_nxt, tf_r, tf_nxt;

  // output register
  logic              out_valid_r;
  act_t              out_act_r;
  logic [DATA_W-1:0] out_rdv_r;
  logic              out_ovf_r, out_tf_r;
  logic              out_load;

  // stack memory port
  logic              stk_we;
  logic [SIW-1:0]    stk_waddr, stk_raddr;
  logic [DATA_W-1:0] stk_wdata, stk_rdata;

  // variable table ports
  logic              nam_we, val_we;
  logic [VIW-1:0]    var_waddr, val_raddr, nam_raddr;
  logic [DATA_W-1:0] val_wdata, val_rdata;
  logic [NW-1:0]     nam_rdata;

  logic              srch_start;
  srch_stat_t        srch_stat;
  logic [VIW-1:0]    srch_idx;

  logic              alu_en;
  alu_op_t           alu_op;
  logic [DATA_W-1:0] alu_y;

  logic              stk_full, stk_empty, tab_full;
  logic [SCW-1:0]    cnt_dec, cnt_dec2, wb_idx;

  assign stk_full  = (cnt_r == SCW'(STACK_DEPTH));
  assign stk_empty = (cnt_r == '0);
  assign tab_full  = (vcnt_r == VCW'(VAR_ENTRIES));
  assign cnt_dec   = cnt_r - SCW'(1);
  assign cnt_dec2  = cnt_r - SCW'(2);
  // ALU result lands where the lower operand was, or at the bottom with one word
  assign wb_idx    = (cnt_r >= SCW'(2)) ? cnt_dec2 : '0;

  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    case (op_r)
      OP_ADD:  alu_op = ALU_ADD;
      OP_SUB:  alu_op = ALU_SUB;
      default: alu_op = ALU_MUL;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    vcnt_nxt   = vcnt_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    opv_nxt    = opv_r;
    act_nxt    = act_r;
    rdv_nxt    = rdv_r;
    ovf_nxt    = ovf_r;
    tf_nxt     = tf_r;
    stk_we     = 1'b0;
    stk_waddr  = cnt_r[SIW-1:0];
    stk_wdata  = val_r;
    stk_raddr  = cnt_dec[SIW-1:0];
    nam_we     = 1'b0;
    val_we     = 1'b0;
    var_waddr  = vcnt_r[VIW-1:0];
    val_wdata  = opv_r;
    val_raddr  = srch_idx;
    srch_start = 1'b0;
    alu_en     = 1'b0;
    out_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        act_nxt = ACT_CONTINUE;
        rdv_nxt = '0;
        ovf_nxt = 1'b0;
        tf_nxt  = 1'b0;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (op_r) inside
          OP_PUSH: begin
            if (stk_full) begin
              ovf_nxt = 1'b1;
            end else begin
              stk_we  = 1'b1;
              cnt_nxt = cnt_r + SCW'(1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            if (stk_empty) begin
              stk_we    = 1'b1;
              stk_wdata = '0;
              cnt_nxt   = SCW'(1);
            end else begin
              state_nxt = S_RD_B;
            end
          end
          OP_WRITE: begin
            if (stk_empty) begin
              opv_nxt    = '0;
              srch_start = 1'b1;
              state_nxt  = S_SEARCH;
            end else begin
              cnt_nxt   = cnt_dec;
              state_nxt = S_POP;
            end
          end
          OP_READ: begin
            if (stk_full) begin
              ovf_nxt = 1'b1;
            end else begin
              srch_start = 1'b1;
              state_nxt  = S_SEARCH;
            end
          end
          OP_JUMP: begin
            act_nxt = exists_r ? ACT_JUMP : ACT_END;
          end
          OP_JUMPZ: begin
            if (!exists_r) begin
              act_nxt = ACT_END;
            end else if (stk_empty) begin
              act_nxt = ACT_JUMP;
            end else begin
              cnt_nxt   = cnt_dec;
              state_nxt = S_POP;
            end
          end
          OP_ASSIGN: begin
            opv_nxt    = val_r;
            srch_start = 1'b1;
            state_nxt  = S_SEARCH;
          end
          OP_QUERY: begin
            srch_start = 1'b1;
            state_nxt  = S_SEARCH;
          end
          default: begin
          end
        endcase
      end

      S_RD_B: begin
        b_nxt     = stk_rdata;
        stk_raddr = cnt_dec2[SIW-1:0];
        if (cnt_r >= SCW'(2)) begin
          state_nxt = S_RD_A;
        end else begin
          a_nxt     = '0;
          state_nxt = S_ALU;
        end
      end

      S_RD_A: begin
        a_nxt     = stk_rdata;
        state_nxt = S_ALU;
      end

      S_ALU: begin
        alu_en    = 1'b1;
        state_nxt = S_WB;
      end

      S_WB: begin
        stk_we    = 1'b1;
        stk_waddr = wb_idx[SIW-1:0];
        stk_wdata = alu_y;
        cnt_nxt   = wb_idx + SCW'(1);
        state_nxt = S_FINISH;
      end

      S_POP: begin
        if (op_r == OP_WRITE) begin
          opv_nxt    = stk_rdata;
          srch_start = 1'b1;
          state_nxt  = S_SEARCH;
        end else begin
          act_nxt   = (stk_rdata == '0) ? ACT_JUMP : ACT_CONTINUE;
          state_nxt = S_FINISH;
        end
      end

      S_SEARCH: begin
        if (srch_stat.done) begin
          state_nxt = S_FINISH;
          if (op_r == OP_READ || op_r == OP_QUERY) begin
            if (srch_stat.hit) begin
              state_nxt = S_VAL_RD;
            end else if (op_r == OP_READ) begin
              stk_we    = 1'b1;
              stk_wdata = '0;
              cnt_nxt   = cnt_r + SCW'(1);
            end
          end else if (srch_stat.hit) begin
            val_we    = 1'b1;
            var_waddr = srch_idx;
          end else if (tab_full) begin
            tf_nxt = 1'b1;
          end else begin
            nam_we   = 1'b1;
            val_we   = 1'b1;
            vcnt_nxt = vcnt_r + VCW'(1);
          end
        end
      end

      S_VAL_RD: begin
        state_nxt = S_FINISH;
        if (op_r == OP_READ) begin
          stk_we    = 1'b1;
          stk_wdata = val_rdata;
          cnt_nxt   = cnt_r + SCW'(1);
        end else begin
          rdv_nxt = val_rdata;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vcnt_r  <= vcnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= op_t'(in_opcode);
      val_r    <= in_operand_value;
      name_r   <= in_name_id[NW-1:0];
      exists_r <= in_target_exists;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    opv_r <= opv_nxt;
    act_r <= act_nxt;
    rdv_r <= rdv_nxt;
    ovf_r <= ovf_nxt;
    tf_r  <= tf_nxt;
    if (out_load) begin
      out_act_r <= act_r;
      out_rdv_r <= rdv_r;
      out_ovf_r <= ovf_r;
      out_tf_r  <= tf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_action    = out_act_r;
  assign out_read_value     = out_rdv_r;
  assign out_stack_overflow = out_ovf_r;
  assign out_table_full     = out_tf_r;

  scu_ram #(
    .W     (DATA_W),
    .DEPTH (STACK_DEPTH),
    .AW    (SIW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  scu_ram #(
    .W     (NW),
    .DEPTH (VAR_ENTRIES),
    .AW    (VIW)
  ) u_names (
    .clk     (clk),
    .wr_en   (nam_we),
    .wr_addr (var_waddr),
    .wr_data (name_r),
    .rd_addr (nam_raddr),
    .rd_data (nam_rdata)
  );

  scu_ram #(
    .W     (DATA_W),
    .DEPTH (VAR_ENTRIES),
    .AW    (VIW)
  ) u_values (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (var_waddr),
    .wr_data (val_wdata),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  scu_search #(
    .NW  (NW),
    .VIW (VIW),
    .VCW (VCW)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .key     (name_r),
    .count   (vcnt_r),
    .rd_addr (nam_raddr),
    .rd_data (nam_rdata),
    .stat    (srch_stat),
    .hit_idx (srch_idx)
  );

  scu_alu u_alu (
    .clk (clk),
    .en  (alu_en),
    .op  (alu_op),
    .a   (a_r),
    .b   (b_r),
    .y   (alu_y)
  );

endmodule

FILE: tb/sv/scu_result_checker.sv
module scu_result_checker import scu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic signed [DATA_W-1:0] in_operand_value,
  input  logic [NAME_ID_W-1:0]     in_name_id,
  input  logic                     in_target_exists,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ACT_W-1:0]         out_next_action,
  input  logic signed [DATA_W-1:0] out_read_value,
  input  logic                     out_stack_overflow,
  input  logic                     out_table_full,
  output int                       err_cnt,
  output int                       pending
);

  localparam int STK_DEPTH   = DEF_STACK_DEPTH;
  localparam int SYM_ENTRIES = DEF_VAR_ENTRIES;
  localparam logic [NAME_ID_W-1:0] NAME_MASK =
    NAME_ID_W'((64'd1 << DEF_NAME_BITS) - 64'd1);
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    act_t              act;
    logic [DATA_W-1:0] rd;
    logic              ovf;
    logic              tfull;
  } calc_result_t;

  // Shadow of the operand stack and the variable table.
  logic [DATA_W-1:0]    stk_mem [STK_DEPTH];
  int                   stk_cnt;
  logic [NAME_ID_W-1:0] sym_names [SYM_ENTRIES];
  logic [DATA_W-1:0]    sym_values [SYM_ENTRIES];
  int                   sym_cnt;

  calc_result_t pending_results[$];
  calc_result_t exp_r;
  int           mismatches = 0;
  int           outstanding = 0;

  assign err_cnt = mismatches;
  assign pending = outstanding;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t scu check: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic bit stk_push(input logic [DATA_W-1:0] v);
    if (stk_cnt >= STK_DEPTH) return 1'b0;
    stk_mem[stk_cnt] = v;
    stk_cnt++;
    return 1'b1;
  endfunction

  // caller guarantees a non-empty stack
  function automatic logic [DATA_W-1:0] stk_pop();
    stk_cnt--;
    return stk_mem[stk_cnt];
  endfunction

  function automatic int sym_find(input logic [NAME_ID_W-1:0] nm);
    for (int k = 0; k < sym_cnt; k++)
      if (sym_names[k] == nm) return k;
    return sym_cnt;
  endfunction

  function automatic bit sym_set(input logic [NAME_ID_W-1:0] nm, input logic [DATA_W-1:0] v);
    int k;
    k = sym_find(nm);
    if (k < sym_cnt) begin
      sym_values[k] = v;
      return 1'b1;
    end
    if (sym_cnt >= SYM_ENTRIES) return 1'b0;
    sym_names[sym_cnt]  = nm;
    sym_values[sym_cnt] = v;
    sym_cnt++;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] sym_get(input logic [NAME_ID_W-1:0] nm);
    int k;
    k = sym_find(nm);
    return (k < sym_cnt) ? sym_values[k] : '0;
  endfunction

  // One instruction against the shadow state; returns its result beat.
  function automatic calc_result_t execute_instr(input logic [OPC_W-1:0] opc,
                                                 input logic [DATA_W-1:0] val,
                                                 input logic [NAME_ID_W-1:0] nm_in,
                                                 input logic tgt);
    calc_result_t         res;
    logic [DATA_W-1:0]    a, b, r, v;
    logic [NAME_ID_W-1:0] nm;
    nm        = nm_in & NAME_MASK;
    res.act   = ACT_CONTINUE;
    res.rd    = '0;
    res.ovf   = 1'b0;
    res.tfull = 1'b0;
    case (opc) inside
      OP_PUSH: res.ovf = !stk_push(val);
      OP_ADD, OP_SUB, OP_MUL: begin
        if (stk_cnt == 0) begin
          void'(stk_push('0));
        end else begin
          b = stk_pop();
          a = (stk_cnt > 0) ? stk_pop() : '0;
          if (opc == OP_ADD)      r = a + b;
          else if (opc == OP_SUB) r = a - b;
          else                    r = a * b;
          void'(stk_push(r));
        end
      end
      OP_WRITE: begin
        v = (stk_cnt > 0) ? stk_pop() : '0;
        res.tfull = !sym_set(nm, v);
      end
      OP_READ: res.ovf = !stk_push(sym_get(nm));
      OP_JUMP: res.act = tgt ? ACT_JUMP : ACT_END;
      OP_JUMPZ: begin
        if (!tgt)              res.act = ACT_END;
        else if (stk_cnt == 0) res.act = ACT_JUMP;
        else                   res.act = (stk_pop() == '0) ? ACT_JUMP : ACT_CONTINUE;
      end
      OP_ASSIGN: res.tfull = !sym_set(nm, val);
      OP_QUERY:  res.rd = sym_get(nm);
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_results.delete();
      stk_cnt     = 0;
      sym_cnt     = 0;
      outstanding = 0;
    end else begin
      // result beat first: it always belongs to an older instruction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_read_value, '0);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_next_action !== exp_r.act)
            report_mismatch("next_action", DATA_W'(out_next_action), DATA_W'(exp_r.act));
          if (out_read_value !== exp_r.rd)
            report_mismatch("read_value", out_read_value, exp_r.rd);
          if (out_stack_overflow !== exp_r.ovf)
            report_mismatch("stack_overflow", DATA_W'(out_stack_overflow),
                            DATA_W'(exp_r.ovf));
          if (out_table_full !== exp_r.tfull)
            report_mismatch("table_full", DATA_W'(out_table_full), DATA_W'(exp_r.tfull));
        end
      end
      if (in_valid && in_ready)
        pending_results.insert(pending_results.size(),
                               execute_instr(in_opcode, in_operand_value, in_name_id,
                                             in_target_exists));
      outstanding = pending_results.size();
    end
  end

endmodule

FILE: tb/sv/stack_calculator_execute_unit_tb.sv
module stack_calculator_execute_unit_tb;
  import scu_pkg::*;

  // Run length and safety net. The slowest legal instruction walks the full
  // name table; with gaps and stalls the limit still leaves a wide margin.
  localparam int N_ITEMS      = 1650;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE       = 64;
  localparam int PHASE_LEN    = 150;
  localparam int NARROW_UNTIL = 650;   // beats using the small name pool

  // Opcodes 10..15 are undefined; the unit must treat them as no-ops.
  localparam logic [OPC_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OPC_W-1:0] OP_UNUSED_HI = 4'd15;

  localparam logic [DATA_W-1:0] W_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] W_ONE  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] W_NEG1 = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] W_MIN  = 32'h8000_0000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OPC_W-1:0]         in_opcode;
  logic signed [DATA_W-1:0] in_operand_value;
  logic [NAME_ID_W-1:0]     in_name_id;
  logic                     in_target_exists;
  logic                     out_valid;
  logic                     out_ready;
  logic [ACT_W-1:0]         out_next_action;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_stack_overflow;
  logic                     out_table_full;

  int err_cnt;
  int pending;
  int cycle_cnt = 0;
  int sent = 0;

  // Idle/stall odds in percent, switched by phase as beats go out.
  int gap_pct   = 0;
  int stall_pct = 0;

  // Name pool: a few names up front so lookups hit, wider later to fill the table.
  logic [NAME_ID_W-1:0] name_pool [48];

  stack_calculator_execute_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand_value  (in_operand_value),
    .in_name_id        (in_name_id),
    .in_target_exists  (in_target_exists),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_action   (out_next_action),
    .out_read_value    (out_read_value),
    .out_stack_overflow(out_stack_overflow),
    .out_table_full    (out_table_full)
  );

  scu_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand_value  (in_operand_value),
    .in_name_id        (in_name_id),
    .in_target_exists  (in_target_exists),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_action   (out_next_action),
    .out_read_value    (out_read_value),
    .out_stack_overflow(out_stack_overflow),
    .out_table_full    (out_table_full),
    .err_cnt           (err_cnt),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: a hung handshake or lost result ends up here.
  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("stack_calculator_execute_unit_tb: done, errors");
    $finish;
  end

  // Result side: out_ready toggles on the falling edge at the phase's stall odds.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Phases rotate: no idling, sender idle, receiver stalling, both.
  function automatic void set_phase();
    case ((sent / PHASE_LEN) % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 74; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 74; end
      default: begin gap_pct = 20; stall_pct = 20; end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid is only raised or lowered once per edge, and held with a stable
  // payload until in_ready is seen at a rising edge.
  task automatic send_instr(input logic [OPC_W-1:0] opc, input logic [DATA_W-1:0] val,
                            input logic [NAME_ID_W-1:0] nm, input logic tgt);
    set_phase();
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= opc;
    in_operand_value <= val;
    in_name_id       <= nm;
    in_target_exists <= tgt;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Operand values lean on the corners: zero drives JUMPZ, the rest wraps.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return W_ZERO;
      1: return W_ONE;
      2: return W_NEG1;
      3: return W_MAX;
      4: return W_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NAME_ID_W-1:0] pick_name();
    if (sent < NARROW_UNTIL) return name_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 99) < 10) return NAME_ID_W'($urandom);
    return name_pool[$urandom_range(0, 47)];
  endfunction

  function automatic logic rand_target();
    return ($urandom_range(0, 99) < 80);
  endfunction

  task automatic mixed_burst(input int n);
    logic [OPC_W-1:0] opc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4)
        opc = OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
        opc = OPC_W'($urandom_range(OP_PUSH, OP_QUERY));
      send_instr(opc, rand_word(), pick_name(), rand_target());
    end
  endtask

  // Push-heavy run: long enough from most depths to hit a full stack.
  task automatic fill_burst(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85)
        send_instr(OP_PUSH, rand_word(), pick_name(), rand_target());
      else
        send_instr(OP_READ, rand_word(), pick_name(), rand_target());
    end
  endtask

  // Pop-heavy run: arithmetic, writes and conditional jumps drain the stack
  // down to the one-operand and empty cases.
  task automatic drain_burst(input int n);
    op_t opc;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: opc = OP_ADD;
        1: opc = OP_SUB;
        2: opc = OP_MUL;
        3: opc = OP_WRITE;
        default: opc = OP_JUMPZ;
      endcase
      send_instr(opc, rand_word(), pick_name(), rand_target());
    end
  endtask

  initial begin
    int ep;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_PUSH;
    in_operand_value = '0;
    in_name_id       = '0;
    in_target_exists = 1'b0;

    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < 48; i++) name_pool[i] = NAME_ID_W'($urandom);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners; the stack contents are tracked in the notes.
    send_instr(OP_ADD,   W_NEG1, '0, 1'b1);          // empty stack -> push 0   [0]
    send_instr(OP_QUERY, W_NEG1, '0, 1'b1);          // absent variable -> 0
    send_instr(OP_READ,  W_NEG1, '1, 1'b1);          // absent -> push 0        [0 0]
    send_instr(OP_JUMPZ, W_ZERO, '1, 1'b1);          // pops 0 -> jump          [0]
    send_instr(OP_JUMPZ, W_ZERO, '1, 1'b1);          // pops 0 -> jump          []
    send_instr(OP_JUMPZ, W_ONE,  '0, 1'b1);          // empty stack -> jump
    send_instr(OP_JUMPZ, W_ONE,  '0, 1'b0);          // missing routine -> end
    send_instr(OP_JUMP,  W_ZERO, '1, 1'b1);
    send_instr(OP_JUMP,  W_ZERO, '1, 1'b0);
    send_instr(OP_WRITE, W_NEG1, 16'h1234, 1'b0);    // empty stack writes 0
    send_instr(OP_PUSH,  W_MAX,  '0, 1'b0);
    send_instr(OP_PUSH,  W_MIN,  '1, 1'b1);
    send_instr(OP_SUB,   W_ZERO, '0, 1'b0);          // max - min wraps to -1   [-1]
    send_instr(OP_SUB,   W_ZERO, '0, 1'b0);          // one operand: 0 - (-1)   [1]
    send_instr(OP_PUSH,  W_NEG1, '0, 1'b0);
    send_instr(OP_MUL,   W_ZERO, '0, 1'b0);          // 1 * -1                  [-1]
    send_instr(OP_MUL,   W_ZERO, '0, 1'b0);          // one operand: 0 * -1     [0]
    send_instr(OP_PUSH,  W_MAX,  '0, 1'b0);
    send_instr(OP_PUSH,  W_ONE,  '0, 1'b0);
    send_instr(OP_ADD,   W_ZERO, '0, 1'b0);          // max + 1 wraps to min    [0 min]
    send_instr(OP_WRITE, W_ZERO, '1, 1'b0);          // var ffff = min          [0]
    send_instr(OP_ASSIGN, W_MAX, '0, 1'b0);          // var 0 = max
    send_instr(OP_QUERY, W_ZERO, '1, 1'b0);          // -> min
    send_instr(OP_UNUSED_HI, W_NEG1, '1, 1'b1);      // undefined opcodes: no-op
    send_instr(OP_UNUSED_LO, W_NEG1, '1, 1'b1);
    send_instr(OP_JUMPZ, W_ZERO, '0, 1'b0);          // missing routine keeps the stack

    // Random episodes; the table fills once the wide name pool opens up.
    while (sent < N_ITEMS) begin
      ep = $urandom_range(0, 9);
      if (ep == 0)      fill_burst(70);
      else if (ep == 1) drain_burst(40);
      else              mixed_burst(20);
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0)
      $display("stack_calculator_execute_unit_tb: done, clean");
    else
      $display("stack_calculator_execute_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/scu_pkg.sv
rtl/scu_ram.sv
rtl/scu_alu.sv
rtl/scu_search.sv
rtl/stack_calculator_execute_unit.sv
tb/sv/scu_result_checker.sv
tb/sv/stack_calculator_execute_unit_tb.sv
